// ----- rtl/numeric_literal_lexer_unit_defines.svh -----
// assertion helpers for the numeric literal lexer
`ifndef NUMERIC_LITERAL_LEXER_UNIT_DEFINES_SVH
`define NUMERIC_LITERAL_LEXER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NLL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("numeric literal lexer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define NLL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("numeric literal lexer assertion failed");

`endif

// ----- rtl/nll_pkg.sv -----
package nll_pkg;

	// one source character request
	typedef struct packed {
		logic [7:0] char_code;
		logic       at_end;
		logic       start_req;
	} src_item_t;

	// one result: a text character or the finished token
	typedef struct packed {
		logic       result_kind;
		logic [7:0] text_char;
		logic [2:0] token_kind;
		logic [7:0] token_length;
		logic [1:0] give_back;
		logic       last;
	} res_item_t;

	// result kinds
	localparam logic RK_TEXT  = 1'b0;
	localparam logic RK_TOKEN = 1'b1;

	// token kinds
	localparam logic [2:0] K_INT   = 3'd0;
	localparam logic [2:0] K_FLOAT = 3'd1;
	localparam logic [2:0] K_HEX   = 3'd2;
	localparam logic [2:0] K_OCT   = 3'd3;
	localparam logic [2:0] K_BIN   = 3'd4;
	localparam logic [2:0] K_BIG   = 3'd5;
	localparam logic [2:0] K_BAD   = 3'd6;

	// characters
	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_1     = "1";
	localparam logic [7:0] CH_7     = "7";
	localparam logic [7:0] CH_9     = "9";
	localparam logic [7:0] CH_POINT = ".";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_UNDER = "_";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_O     = "o";
	localparam logic [7:0] CH_B     = "b";
	localparam logic [7:0] CH_N     = "n";
	localparam logic [7:0] CH_E_LO  = "e";
	localparam logic [7:0] CH_E_UP  = "E";
	localparam logic [7:0] CH_F_LO  = "f";
	localparam logic [7:0] CH_F_UP  = "F";
	localparam logic [7:0] CH_D_LO  = "d";
	localparam logic [7:0] CH_D_UP  = "D";
	localparam logic [7:0] CH_L_LO  = "l";
	localparam logic [7:0] CH_L_UP  = "L";
	localparam logic [7:0] CH_A_LO  = "a";
	localparam logic [7:0] CH_A_UP  = "A";
	localparam logic [7:0] CH_Z_LO  = "z";
	localparam logic [7:0] CH_Z_UP  = "Z";

endpackage

// ----- rtl/numeric_literal_lexer_unit.sv -----
// Numeric literal lexer: takes one source character request per cycle while src_ready
// is high and scans a numeric literal that begins at a request marked start_req. It
// echoes the normalized literal text one character per result ("0." for a leading
// point, ".0" for a bare trailing point) and closes with one token result carrying the
// kind (int, float, hex, octal, binary, bigint, invalid), the text length saturated at
// 255 and give_back, the count of most recent characters the token did not consume and
// that the caller should present again. An invalid token reports length zero. The
// final result of each request has last set; a request with no start while idle yields
// nothing. A request is registered on acceptance and classified once the result queue
// has room, and its 0 to 3 results are pushed into a 4-entry result queue. Requests are
// taken one per cycle as long as the queue holds at most one result; the output port
// drains one result per cycle while res_ready is high, so a request causing two or three
// results holds off the input. MAX_TEXT_LEN sets the internal length counter's ceiling.
module numeric_literal_lexer_unit #(
	parameter int MAX_TEXT_LEN = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  nll_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_ready,
	output nll_pkg::res_item_t res_item
);

	import nll_pkg::*;

`include "numeric_literal_lexer_unit_defines.svh"

	// length counter width and a width wide enough to compare against 255
	localparam int CW = $clog2(MAX_TEXT_LEN + 1);
	localparam int LW = (CW > 8) ? CW : 8;

	// result queue geometry
	localparam int DEPTH   = 4;
	localparam int MAX_RES = 3;
	localparam int PW      = $clog2(DEPTH);
	localparam int QW      = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		P_IDLE,
		P_ZERO,
		P_LEAD_DOT,
		P_INT,
		P_INT_DOT,
		P_FRAC,
		P_EXP_SIGN,
		P_EXP_FIRST,
		P_EXP_DIG,
		P_BASED
	} phase_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_A_LO) && (c <= CH_Z_LO)) || ((c >= CH_A_UP) && (c <= CH_Z_UP));
	endfunction

	function automatic logic is_suffix(input logic [7:0] c);
		return (c == CH_F_LO) || (c == CH_F_UP) || (c == CH_D_LO) || (c == CH_D_UP) ||
			(c == CH_L_LO) || (c == CH_L_UP);
	endfunction

	function automatic logic in_base(input logic [2:0] kind, input logic [7:0] c);
		logic hex_alpha;
		hex_alpha = ((c >= CH_A_LO) && (c <= CH_F_LO)) || ((c >= CH_A_UP) && (c <= CH_F_UP));
		if (kind == K_HEX) begin
			return is_digit(c) || hex_alpha;
		end else if (kind == K_OCT) begin
			return (c >= CH_0) && (c <= CH_7);
		end
		return (c == CH_0) || (c == CH_1);
	endfunction

	// scanner state
	phase_t          phase_q;
	logic [2:0]      kind_q;
	logic            point_q;
	logic [CW-1:0]   count_q;

	// input register
	logic            valid_s1;
	src_item_t       item_s1;

	// result queue
	res_item_t       fifo_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [QW-1:0]   fill_q;

	// decode outputs
	phase_t          nxt_phase;
	logic [2:0]      nxt_kind;
	logic            nxt_point;
	logic [1:0]      txt_n;
	logic [7:0]      txt_c [MAX_RES];
	logic            fin;
	logic [2:0]      fin_kind;
	logic [1:0]      fin_gb;
	logic [CW-1:0]   count_base;
	logic [CW:0]     count_sum;
	logic [CW-1:0]   count_new;
	logic [LW-1:0]   len_ext;
	logic [7:0]      tok_len;
	res_item_t       res_v [MAX_RES];
	logic [1:0]      n_res;

	logic            process;
	logic            pop;
	logic [7:0]      c;
	logic            e;

	assign c = item_s1.char_code;
	assign e = item_s1.at_end;

	// room for the worst case of three results before a request is classified
	assign process   = valid_s1 && (fill_q <= QW'(DEPTH - MAX_RES));
	assign src_ready = !valid_s1 || process;
	assign res_valid = (fill_q != '0);
	assign res_item  = fifo_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	// character classification, one request per pass
	always_comb begin
		nxt_phase = phase_q;
		nxt_kind  = kind_q;
		nxt_point = point_q;
		txt_n     = 2'd0;
		for (int k = 0; k < MAX_RES; k++) begin
			txt_c[k] = 8'd0;
		end
		fin      = 1'b0;
		fin_kind = K_INT;
		fin_gb   = 2'd0;

		if (item_s1.start_req) begin
			// new attempt, drops whatever was in flight
			nxt_phase = P_IDLE;
			nxt_kind  = K_INT;
			nxt_point = 1'b0;
			if (e) begin
				fin      = 1'b1;
				fin_kind = K_BAD;
			end else if (c == CH_0) begin
				nxt_phase = P_ZERO;
			end else if (is_digit(c)) begin
				txt_c[txt_n] = c;
				txt_n        = txt_n + 2'd1;
				nxt_phase    = P_INT;
			end else if (c == CH_POINT) begin
				nxt_phase = P_LEAD_DOT;
			end else begin
				fin      = 1'b1;
				fin_kind = K_BAD;
				fin_gb   = 2'd1;
			end
		end else begin
			case (phase_q)
				P_ZERO, P_INT: begin
					if (phase_q == P_ZERO && !e && (c == CH_X || c == CH_O || c == CH_B)) begin
						nxt_kind = (c == CH_X) ? K_HEX : (c == CH_O) ? K_OCT : K_BIN;
						txt_c[0]  = CH_0;
						txt_c[1]  = c;
						txt_n     = 2'd2;
						nxt_phase = P_BASED;
					end else begin
						// a held zero is echoed, then the character is taken as integer
						if (phase_q == P_ZERO) begin
							txt_c[txt_n] = CH_0;
							txt_n        = txt_n + 2'd1;
							nxt_phase    = P_INT;
						end
						if (e) begin
							fin = 1'b1;
						end else if (is_digit(c)) begin
							txt_c[txt_n] = c;
							txt_n        = txt_n + 2'd1;
						end else if (c == CH_N) begin
							txt_c[txt_n] = c;
							txt_n        = txt_n + 2'd1;
							fin          = 1'b1;
							fin_kind     = K_BIG;
						end else if (c == CH_POINT) begin
							nxt_phase = P_INT_DOT;
						end else if (is_suffix(c)) begin
							txt_c[txt_n] = c;
							txt_n        = txt_n + 2'd1;
							fin          = 1'b1;
							fin_kind     = K_FLOAT;
						end else begin
							fin    = 1'b1;
							fin_gb = 2'd1;
						end
					end
				end
				P_LEAD_DOT: begin
					if (!e && is_digit(c)) begin
						nxt_point = 1'b1;
						txt_c[0]  = CH_0;
						txt_c[1]  = CH_POINT;
						txt_c[2]  = c;
						txt_n     = 2'd3;
						nxt_phase = P_FRAC;
					end else begin
						fin      = 1'b1;
						fin_kind = K_BAD;
						fin_gb   = e ? 2'd1 : 2'd2;
					end
				end
				P_INT_DOT: begin
					if (!e && (is_alpha(c) || c == CH_UNDER)) begin
						// method call on an integer, point and this character go back
						fin    = 1'b1;
						fin_gb = 2'd2;
					end else if (!e && is_digit(c)) begin
						nxt_point = 1'b1;
						txt_c[0]  = CH_POINT;
						txt_c[1]  = c;
						txt_n     = 2'd2;
						nxt_phase = P_FRAC;
					end else begin
						nxt_point = 1'b1;
						txt_c[0]  = CH_POINT;
						txt_c[1]  = CH_0;
						txt_n     = 2'd2;
						fin       = 1'b1;
						fin_kind  = K_FLOAT;
						fin_gb    = e ? 2'd0 : 2'd1;
					end
				end
				P_FRAC, P_EXP_DIG: begin
					fin_kind = K_FLOAT;
					if (e) begin
						fin = 1'b1;
					end else if (is_digit(c)) begin
						txt_c[0] = c;
						txt_n    = 2'd1;
					end else if (phase_q == P_FRAC && (c == CH_E_LO || c == CH_E_UP)) begin
						txt_c[0]  = c;
						txt_n     = 2'd1;
						nxt_phase = P_EXP_SIGN;
					end else if (is_suffix(c)) begin
						txt_c[0] = c;
						txt_n    = 2'd1;
						fin      = 1'b1;
					end else begin
						fin    = 1'b1;
						fin_gb = 2'd1;
					end
				end
				P_EXP_SIGN, P_EXP_FIRST: begin
					if (phase_q == P_EXP_SIGN && !e && (c == CH_PLUS || c == CH_MINUS)) begin
						txt_c[0]  = c;
						txt_n     = 2'd1;
						nxt_phase = P_EXP_FIRST;
					end else if (!e && is_digit(c)) begin
						txt_c[0]  = c;
						txt_n     = 2'd1;
						nxt_phase = P_EXP_DIG;
					end else begin
						// exponent with no digits
						fin      = 1'b1;
						fin_kind = K_BAD;
						fin_gb   = e ? 2'd0 : 2'd1;
					end
				end
				P_BASED: begin
					fin_kind = kind_q;
					if (e) begin
						fin = 1'b1;
					end else if (in_base(kind_q, c)) begin
						txt_c[0] = c;
						txt_n    = 2'd1;
					end else if (is_suffix(c)) begin
						txt_c[0] = c;
						txt_n    = 2'd1;
						fin      = 1'b1;
						fin_kind = K_FLOAT;
					end else begin
						fin    = 1'b1;
						fin_gb = 2'd1;
					end
				end
				default: begin
					// idle without a start: request is dropped
					nxt_phase = P_IDLE;
				end
			endcase
		end

		if (fin) begin
			nxt_phase = P_IDLE;
		end
	end

	// saturating text length after this request's echoes
	always_comb begin
		count_base = item_s1.start_req ? '0 : count_q;
		count_sum  = {1'b0, count_base} + (CW + 1)'(txt_n);
		if (count_sum > (CW + 1)'(MAX_TEXT_LEN)) begin
			count_new = CW'(MAX_TEXT_LEN);
		end else begin
			count_new = count_sum[CW-1:0];
		end
		len_ext = LW'(count_new);
		if (fin_kind == K_BAD) begin
			tok_len = 8'd0;
		end else if (len_ext > LW'(255)) begin
			tok_len = 8'hff;
		end else begin
			tok_len = len_ext[7:0];
		end
	end

	// text results first, then the token, last flag on the final one
	always_comb begin
		n_res = txt_n + {1'b0, fin};
		for (int k = 0; k < MAX_RES; k++) begin
			res_v[k] = '0;
			if (2'(k) < txt_n) begin
				res_v[k].result_kind = RK_TEXT;
				res_v[k].text_char   = txt_c[k];
			end else if (fin && 2'(k) == txt_n) begin
				res_v[k].result_kind  = RK_TOKEN;
				res_v[k].token_kind   = fin_kind;
				res_v[k].token_length = tok_len;
				res_v[k].give_back    = fin_gb;
			end
			res_v[k].last = (2'(k) + 2'd1 == n_res);
		end
	end

	// scanner state, input register control and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			kind_q   <= K_INT;
			point_q  <= 1'b0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (src_ready) begin
				valid_s1 <= src_valid;
			end
			if (process) begin
				phase_q  <= nxt_phase;
				kind_q   <= nxt_kind;
				point_q  <= nxt_point;
				count_q  <= count_new;
				wr_ptr_q <= wr_ptr_q + PW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			fill_q <= fill_q + (process ? QW'(n_res) : QW'(0)) - (pop ? QW'(1) : QW'(0));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_item;
		end
		if (process) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (2'(k) < n_res) begin
					fifo_q[wr_ptr_q + PW'(k)] <= res_v[k];
				end
			end
		end
	end

	`NLL_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= QW'(DEPTH))
	`NLL_ASSERT_IMP(a_frac_point, phase_q == P_FRAC || phase_q == P_EXP_DIG, point_q)
	`NLL_ASSERT_IMP(a_token_last, res_valid && res_item.result_kind == RK_TOKEN, res_item.last)
	`NLL_ASSERT_IMP(a_based_kind, phase_q == P_BASED,
		kind_q == K_HEX || kind_q == K_OCT || kind_q == K_BIN)
	`NLL_ASSERT_NXT(a_pop_fill, pop && !process, fill_q == $past(fill_q) - QW'(1))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import nll_pkg::*;

	// lexer length ceiling, kept equal to the instance parameter
	localparam int MAX_TEXT     = 255;
	// receiver hold-off that fills the result queue and stalls the source
	localparam int HOLD_CYCLES  = 60;
	// counted requests per idling phase
	localparam int PHASE_ITEMS  = 48;
	// digits after the first one in the literal that saturates the length
	localparam int LONG_DIGITS  = 259;
	// bound on the final drain and the quiet tail after it
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 20;
	localparam int REPORT_LIMIT = 10;

	// scanner states of the lexer being predicted
	typedef enum logic [3:0] {
		S_IDLE, S_ZERO, S_LEAD_DOT, S_INT, S_INT_DOT, S_FRAC,
		S_EXP_SIGN, S_EXP_FIRST, S_EXP_DIG, S_BASED
	} scan_state_t;

	// idling of the two channels, one setting per phase
	typedef enum logic [1:0] {M_NONE, M_SEND_IDLE, M_RECV_STALL, M_BOTH} gap_mode_t;

	// one row of the directed table; typed rows carry their single expected
	// outcome (nothing, or one token), the rest are checked by the predictor
	typedef struct packed {
		logic       st;
		logic       fin;
		logic [7:0] ch;
		logic       typed;
		logic       none;
		logic [2:0] kind;
		logic [1:0] gb;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_ready;
	src_item_t  src_item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_item_t  res_item;

	// predictor state
	scan_state_t scan_st = S_IDLE;
	logic [2:0]  lit_kind = K_INT;
	logic        point_seen = 1'b0;
	int          txt_cnt = 0;

	// results of the request being predicted, then all results still due
	res_item_t   step_buf[$];
	res_item_t   lex_results_due[$];

	int          err_cnt = 0;
	gap_mode_t   gap_mode = M_NONE;
	logic        hold_tog = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;

	// directed rows: stray char while idle, non-literal starts, lone points,
	// hex with a foreign byte, bad exponent, method call, bigint, and a start
	// left open so the next attempt restarts it
	dir_row_t dir_tab [25] = '{
		'{1'b0, 1'b0, CH_X,     1'b1, 1'b1, K_INT,   2'd0},
		'{1'b1, 1'b0, CH_A_UP,  1'b1, 1'b0, K_BAD,   2'd1},
		'{1'b1, 1'b1, 8'h00,    1'b1, 1'b0, K_BAD,   2'd0},
		'{1'b1, 1'b0, 8'hFF,    1'b1, 1'b0, K_BAD,   2'd1},
		'{1'b1, 1'b0, CH_POINT, 1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_Z_LO,  1'b1, 1'b0, K_BAD,   2'd2},
		'{1'b1, 1'b0, CH_POINT, 1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b1, 8'hFF,    1'b1, 1'b0, K_BAD,   2'd1},
		'{1'b1, 1'b0, CH_0,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_X,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_F_UP,  1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, 8'hFF,    1'b0, 1'b0, K_INT,   2'd0},
		'{1'b1, 1'b0, CH_1,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_POINT, 1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_7,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_E_LO,  1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_PLUS,  1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_A_LO,  1'b1, 1'b0, K_BAD,   2'd1},
		'{1'b1, 1'b0, CH_9,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_POINT, 1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_UNDER, 1'b0, 1'b0, K_INT,   2'd0},
		'{1'b1, 1'b0, CH_1,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_N,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b1, 1'b0, CH_7,     1'b0, 1'b0, K_INT,   2'd0},
		'{1'b0, 1'b0, CH_POINT, 1'b0, 1'b0, K_INT,   2'd0}
	};

	numeric_literal_lexer_unit #(
		.MAX_TEXT_LEN(MAX_TEXT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor: character classes
	// ---------------------------------------------------------------

	function automatic bit is_dig(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
	endfunction

	function automatic bit is_sfx(logic [7:0] c);
		return c == CH_F_LO || c == CH_F_UP || c == CH_D_LO || c == CH_D_UP ||
			c == CH_L_LO || c == CH_L_UP;
	endfunction

	// digit of the current radix; hex takes a-f in either case
	function automatic bit in_radix(logic [7:0] c);
		if (lit_kind == K_HEX)
			return is_dig(c) || (c >= CH_A_LO && c <= CH_F_LO) ||
				(c >= CH_A_UP && c <= CH_F_UP);
		if (lit_kind == K_OCT)
			return c >= CH_0 && c <= CH_7;
		return c == CH_0 || c == CH_1;
	endfunction

	// ---------------------------------------------------------------
	// predictor: result building
	// ---------------------------------------------------------------

	function automatic void emit(logic rk, logic [7:0] ch, logic [2:0] tk,
			logic [7:0] len, logic [1:0] gb);
		res_item_t r;
		if (step_buf.size() >= 4)
			return;
		r.result_kind  = rk;
		r.text_char    = ch;
		r.token_kind   = tk;
		r.token_length = len;
		r.give_back    = gb;
		r.last         = 1'b0;
		step_buf.push_back(r);
	endfunction

	// echoed text keeps counting up to the ceiling, the echo itself never stops
	function automatic void put_text(logic [7:0] c);
		if (txt_cnt < MAX_TEXT)
			txt_cnt++;
		emit(RK_TEXT, c, '0, '0, '0);
	endfunction

	// invalid tokens report length zero, everything else the saturated count
	function automatic void close_token(logic [2:0] kind, logic [1:0] gb);
		int n;
		n = (kind == K_BAD) ? 0 : txt_cnt;
		if (n > 255)
			n = 255;
		emit(RK_TOKEN, '0, kind, n[7:0], gb);
		scan_st = S_IDLE;
	endfunction

	// ---------------------------------------------------------------
	// predictor: per-state handling
	// ---------------------------------------------------------------

	function automatic void on_int(logic [7:0] c, logic fin);
		if (fin)
			close_token(K_INT, 2'd0);
		else if (is_dig(c))
			put_text(c);
		else if (c == CH_N) begin
			// bigint suffix, only reachable without a point
			put_text(c);
			close_token(K_BIG, 2'd0);
		end else if (c == CH_POINT)
			scan_st = S_INT_DOT;
		else if (is_sfx(c)) begin
			put_text(c);
			close_token(K_FLOAT, 2'd0);
		end else
			close_token(K_INT, 2'd1);
	endfunction

	function automatic void on_frac(logic [7:0] c, logic fin);
		if (fin)
			close_token(K_FLOAT, 2'd0);
		else if (is_dig(c))
			put_text(c);
		else if (c == CH_E_LO || c == CH_E_UP) begin
			put_text(c);
			scan_st = S_EXP_SIGN;
		end else if (is_sfx(c)) begin
			put_text(c);
			close_token(K_FLOAT, 2'd0);
		end else
			// a second point lands here too and ends the float
			close_token(K_FLOAT, 2'd1);
	endfunction

	function automatic void on_exp(logic [7:0] c, logic fin);
		if (fin)
			close_token(K_FLOAT, 2'd0);
		else if (is_dig(c))
			put_text(c);
		else if (is_sfx(c)) begin
			put_text(c);
			close_token(K_FLOAT, 2'd0);
		end else
			close_token(K_FLOAT, 2'd1);
	endfunction

	function automatic void on_radix(logic [7:0] c, logic fin);
		if (fin)
			close_token(lit_kind, 2'd0);
		else if (in_radix(c))
			put_text(c);
		else if (is_sfx(c)) begin
			put_text(c);
			close_token(K_FLOAT, 2'd0);
		end else
			close_token(lit_kind, 2'd1);
	endfunction

	// a start drops whatever attempt is open and begins a fresh one
	function automatic void on_start(logic [7:0] c, logic fin);
		scan_st    = S_IDLE;
		lit_kind   = K_INT;
		point_seen = 1'b0;
		txt_cnt    = 0;
		if (fin)
			close_token(K_BAD, 2'd0);
		else if (c == CH_0)
			scan_st = S_ZERO;
		else if (is_dig(c)) begin
			put_text(c);
			scan_st = S_INT;
		end else if (c == CH_POINT)
			scan_st = S_LEAD_DOT;
		else
			close_token(K_BAD, 2'd1);
	endfunction

	// works out the results of one accepted request into step_buf
	function automatic void scan_char(src_item_t it);
		logic [7:0] c;
		logic       fin;
		res_item_t  r;
		c   = it.char_code;
		fin = it.at_end;
		step_buf.delete();
		if (it.start_req)
			on_start(c, fin);
		else begin
			case (scan_st)
				S_ZERO: begin
					if (!fin && (c == CH_X || c == CH_O || c == CH_B)) begin
						lit_kind = (c == CH_X) ? K_HEX : (c == CH_O) ? K_OCT : K_BIN;
						put_text(CH_0);
						put_text(c);
						scan_st = S_BASED;
					end else begin
						// the held zero is echoed late, then handled as an integer
						put_text(CH_0);
						scan_st = S_INT;
						on_int(c, fin);
					end
				end
				S_LEAD_DOT: begin
					if (!fin && is_dig(c)) begin
						point_seen = 1'b1;
						put_text(CH_0);
						put_text(CH_POINT);
						put_text(c);
						scan_st = S_FRAC;
					end else
						close_token(K_BAD, fin ? 2'd1 : 2'd2);
				end
				S_INT: on_int(c, fin);
				S_INT_DOT: begin
					if (!fin && (is_alpha(c) || c == CH_UNDER))
						// method call: the point and this char go back
						close_token(K_INT, 2'd2);
					else if (!fin && is_dig(c)) begin
						point_seen = 1'b1;
						put_text(CH_POINT);
						put_text(c);
						scan_st = S_FRAC;
					end else begin
						// bare trailing point gains a zero
						point_seen = 1'b1;
						put_text(CH_POINT);
						put_text(CH_0);
						close_token(K_FLOAT, fin ? 2'd0 : 2'd1);
					end
				end
				S_FRAC: on_frac(c, fin);
				S_EXP_SIGN: begin
					if (!fin && (c == CH_PLUS || c == CH_MINUS)) begin
						put_text(c);
						scan_st = S_EXP_FIRST;
					end else if (!fin && is_dig(c)) begin
						put_text(c);
						scan_st = S_EXP_DIG;
					end else
						close_token(K_BAD, fin ? 2'd0 : 2'd1);
				end
				S_EXP_FIRST: begin
					if (!fin && is_dig(c)) begin
						put_text(c);
						scan_st = S_EXP_DIG;
					end else
						close_token(K_BAD, fin ? 2'd0 : 2'd1);
				end
				S_EXP_DIG: on_exp(c, fin);
				S_BASED: on_radix(c, fin);
				default: scan_st = S_IDLE;
			endcase
		end
		if (step_buf.size() > 0) begin
			r = step_buf.pop_back();
			r.last = 1'b1;
			step_buf.push_back(r);
		end
	endfunction

	function automatic void book_results();
		foreach (step_buf[i])
			lex_results_due.push_back(step_buf[i]);
	endfunction

	// ---------------------------------------------------------------
	// random request content
	// ---------------------------------------------------------------

	// weighted toward chars that move the scanner on
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 38)
			return CH_0 + 8'($urandom_range(9));
		if (r < 48)
			return CH_POINT;
		if (r < 55)
			return $urandom_range(1) ? CH_E_LO : CH_E_UP;
		if (r < 60)
			return $urandom_range(1) ? CH_PLUS : CH_MINUS;
		if (r < 66)
			case ($urandom_range(2))
				0: return CH_X;
				1: return CH_O;
				default: return CH_B;
			endcase
		if (r < 70)
			return CH_N;
		if (r < 76)
			case ($urandom_range(5))
				0: return CH_F_LO;
				1: return CH_F_UP;
				2: return CH_D_LO;
				3: return CH_D_UP;
				4: return CH_L_LO;
				default: return CH_L_UP;
			endcase
		if (r < 84)
			return ($urandom_range(1) ? CH_A_LO : CH_A_UP) + 8'($urandom_range(5));
		if (r < 90)
			return $urandom_range(3) == 0 ? CH_UNDER : CH_A_LO + 8'($urandom_range(25));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_start();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return CH_1 + 8'($urandom_range(8));
		if (r < 60)
			return CH_0;
		if (r < 80)
			return CH_POINT;
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed literals; some restarts, early ends and stray chars
	function automatic src_item_t next_src();
		src_item_t it;
		int        r;
		it.char_code = pick_char();
		it.at_end    = 1'b0;
		it.start_req = 1'b0;
		r = $urandom_range(99);
		if (scan_st == S_IDLE) begin
			if (r < 8)
				it.char_code = 8'($urandom_range(255));
			else begin
				it.start_req = 1'b1;
				it.char_code = pick_start();
				if ($urandom_range(99) < 5) begin
					it.at_end    = 1'b1;
					it.char_code = 8'($urandom_range(255));
				end
			end
		end else if (r < 3) begin
			it.start_req = 1'b1;
			it.char_code = pick_start();
		end else if (r < 9) begin
			it.at_end    = 1'b1;
			it.char_code = 8'($urandom_range(255));
		end
		return it;
	endfunction

	// ---------------------------------------------------------------
	// source side
	// ---------------------------------------------------------------

	function automatic bit send_gap();
		case (gap_mode)
			M_SEND_IDLE: return $urandom_range(99) < 79;
			M_BOTH:      return $urandom_range(99) < 10;
			default:     return 1'b0;
		endcase
	endfunction

	// presents one request and returns at the edge that accepts it
	task automatic offer(input src_item_t it);
		if (send_gap()) begin
			src_valid <= 1'b0;
			@(posedge clk);
			while (send_gap())
				@(posedge clk);
		end
		src_item  <= it;
		src_valid <= 1'b1;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
	endtask

	// offer, predict and book in one go
	task automatic send_char(input src_item_t it);
		offer(it);
		scan_char(it);
		book_results();
	endtask

	// source goes quiet until every due result has come back
	task automatic settle();
		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (lex_results_due.size() != 0);
	endtask

	initial begin
		src_item_t it;
		int        counted;
		bit        ignored;
		int        waited;

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			it.char_code = dir_tab[i].ch;
			it.at_end    = dir_tab[i].fin;
			it.start_req = dir_tab[i].st;
			offer(it);
			scan_char(it);
			if (dir_tab[i].typed) begin
				step_buf.delete();
				if (!dir_tab[i].none)
					step_buf.push_back('{RK_TOKEN, 8'd0, dir_tab[i].kind, 8'd0,
						dir_tab[i].gb, 1'b1});
			end
			book_results();
		end
		settle();

		for (int m = 0; m < 4; m++) begin
			gap_mode = gap_mode_t'(m);
			if (gap_mode == M_NONE) begin
				// receiver holds off while the source keeps pushing
				hold_tog = ~hold_tog;
				// one literal long enough to saturate the length
				it = '{CH_1, 1'b0, 1'b1};
				send_char(it);
				for (int k = 0; k < LONG_DIGITS; k++) begin
					it = '{CH_0 + 8'($urandom_range(9)), 1'b0, 1'b0};
					send_char(it);
				end
				it = '{8'($urandom_range(255)), 1'b1, 1'b0};
				send_char(it);
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				it      = next_src();
				ignored = scan_st == S_IDLE && !it.start_req;
				send_char(it);
				if (!ignored)
					counted++;
			end
			settle();
		end

		// drain, then a quiet tail that catches stray results
		waited = 0;
		while (lex_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (lex_results_due.size() != 0) begin
			$display("%0d results never arrived", lex_results_due.size());
			err_cnt += lex_results_due.size();
		end
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	function automatic bit recv_stall();
		case (gap_mode)
			M_RECV_STALL: return $urandom_range(99) < 79;
			M_BOTH:       return $urandom_range(99) < 10;
			default:      return 1'b0;
		endcase
	endfunction

	// ready with random stalls; a toggle from the source side starts a long hold
	always @(posedge clk) begin
		if (!arst_n)
			res_ready <= 1'b0;
		else if (hold_seen != hold_tog) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else
			res_ready <= !recv_stall();
	end

	// every accepted result against the oldest one due
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (lex_results_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_LIMIT)
					$display("unexpected result: rk=%0d ch=%02h tk=%0d len=%0d gb=%0d last=%0d",
						res_item.result_kind, res_item.text_char, res_item.token_kind,
						res_item.token_length, res_item.give_back, res_item.last);
			end else begin
				want = lex_results_due.pop_front();
				if (want.result_kind !== res_item.result_kind ||
						want.text_char !== res_item.text_char ||
						want.token_kind !== res_item.token_kind ||
						want.token_length !== res_item.token_length ||
						want.give_back !== res_item.give_back ||
						want.last !== res_item.last) begin
					err_cnt++;
					if (err_cnt <= REPORT_LIMIT) begin
						$display("mismatch expected: rk=%0d ch=%02h tk=%0d len=%0d gb=%0d last=%0d",
							want.result_kind, want.text_char, want.token_kind,
							want.token_length, want.give_back, want.last);
						$display("         actual:   rk=%0d ch=%02h tk=%0d len=%0d gb=%0d last=%0d",
							res_item.result_kind, res_item.text_char, res_item.token_kind,
							res_item.token_length, res_item.give_back, res_item.last);
					end
				end
			end
		end
	end

	// hard stop for a hung handshake
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
